/* hdl/hpvt_pkg.sv */
// ----------------------------------------------------------------------------
// hpvt_pkg
// Shared types and constants of the homogeneous point and vector transform.
// ----------------------------------------------------------------------------
package hpvt_pkg;

   // Fraction bits of every matrix entry and coordinate.
   localparam int FRAC_BITS = 16;

   // Accumulator width of one dot product.
   localparam int ACC_W = 64;

   // Quotient bits that the divider resolves; one more than the result needs
   // so that a saturation toward the negative limit is seen.
   localparam int DIV_STEPS = 33;

   // Remainder width: magnitude of the accumulator plus the quotient span.
   localparam int REM_W = ACC_W + DIV_STEPS;

   // Divider depth: one setup stage plus one stage per quotient bit.
   localparam int DIV_LAT = DIV_STEPS + 1;

   // Fixed-point one in a matrix entry and in the accumulator.
   localparam logic signed [31:0]      ENTRY_ONE = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ACC_ONE   = 64'sd1 <<< (2 * FRAC_BITS - 2);

   // Limits of a result component.
   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   // Item kinds.
   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_POINT  = 2'd1,
      MODE_VECTOR = 2'd2,
      MODE_NORMAL = 2'd3
   } mode_type;

   // Everything that travels alongside the divider for one item.
   typedef struct packed {
      logic [2:0][31:0] direct;
      logic             dir_ov;
      logic             w_zero;
      logic             div_sel;
      logic [2:0]       neg;
      logic [2:0]       nonneg;
   } side_type;

endpackage

/* hdl/hpvt_req_if.sv */
// ----------------------------------------------------------------------------
// hpvt_req_if
// Request channel: load or transform items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpvt_req_if import hpvt_pkg::*; ();

   logic               valid;
   logic               ready;
   mode_type           mode;
   logic               use_inverse;
   logic [3:0]         entry_index;
   logic signed [31:0] entry_value;
   logic signed [31:0] in_x;
   logic signed [31:0] in_y;
   logic signed [31:0] in_z;

   modport source (
      output valid, mode, use_inverse, entry_index, entry_value, in_x, in_y, in_z,
      input  ready
   );

   modport sink (
      input  valid, mode, use_inverse, entry_index, entry_value, in_x, in_y, in_z,
      output ready
   );

endinterface

/* hdl/hpvt_rsp_if.sv */
// ----------------------------------------------------------------------------
// hpvt_rsp_if
// Response channel: transformed coordinates and flags with valid/ready.
// ----------------------------------------------------------------------------
interface hpvt_rsp_if ();

   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic               zero_w;
   logic               overflowed;

   modport source (
      output valid, out_x, out_y, out_z, zero_w, overflowed,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_z, zero_w, overflowed,
      output ready
   );

endinterface

/* hdl/hpvt_div.sv */
// ----------------------------------------------------------------------------
// hpvt_div
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), one quotient
// bit per stage, with a flag for quotients that do not fit DIV_STEPS bits.
// ----------------------------------------------------------------------------
module hpvt_div import hpvt_pkg::*; (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [ACC_W-1:0]     num,
   input  logic [ACC_W-1:0]     den,
   output logic [DIV_STEPS-1:0] quo,
   output logic                 ovf
);

   logic [REM_W-1:0]     rem_ff [DIV_STEPS+1];
   logic [ACC_W-1:0]     den_ff [DIV_STEPS+1];
   logic [DIV_STEPS-1:0] quo_ff [DIV_STEPS+1];
   logic                 ovf_ff [DIV_STEPS+1];

   logic [REM_W-1:0] num_scaled;
   logic [REM_W-1:0] den_top;

   // Setup: scale the numerator and check the quotient range up front.
   always_comb begin
      num_scaled = REM_W'(num) << FRAC_BITS;
      den_top    = REM_W'(den) << DIV_STEPS;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= num_scaled;
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= (num_scaled >= den_top);
      end
   end

   // One compare and subtract per stage, most significant quotient bit first.
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      localparam int Pos = DIV_STEPS - 1 - j;
      logic [REM_W-1:0] trial;
      logic             fits;

      always_comb begin
         trial = REM_W'(den_ff[j]) << Pos;
         fits  = (rem_ff[j] >= trial);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j+1] <= fits ? (rem_ff[j] - trial) : rem_ff[j];
            den_ff[j+1] <= den_ff[j];
            quo_ff[j+1] <= quo_ff[j] | (DIV_STEPS'(fits) << Pos);
            ovf_ff[j+1] <= ovf_ff[j];
         end
      end
   end

   assign quo = quo_ff[DIV_STEPS];
   assign ovf = ovf_ff[DIV_STEPS];

endmodule

/* hdl/homogeneous_point_vector_transform.sv */
// ----------------------------------------------------------------------------
// homogeneous_point_vector_transform
// Applies a stored 4x4 Q16.16 matrix to points, vectors and normals.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the response side stalls.
// Each transform result passes through forty register stages on its way to
// the response channel: five for matrix selection, products, sums and the
// classification of w, a 34-stage divider that resolves one quotient bit per
// stage for the perspective division, and the output register. A load item
// writes its matrix entry at its own transfer and is seen by the very next
// item; it returns nothing. When the response side holds off, the whole
// pipeline holds and req_bus.ready drops until the waiting result is taken.
// ----------------------------------------------------------------------------
module homogeneous_point_vector_transform import hpvt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   hpvt_req_if.sink   req_bus,
   hpvt_rsp_if.source rsp_bus
);

   logic advance;
   logic accept;

   // Matrix storage.
   logic signed [31:0] fwd_ff [16];
   logic signed [31:0] inv_ff [16];

   // Selection, ahead of the first stage.
   logic               src_inv;
   logic signed [31:0] msel [16];
   logic signed [31:0] e_in [4][3];
   logic signed [31:0] t_in [4];

   // Stage 1: selected entries and coordinates.
   logic               s1_valid_ff;
   logic               s1_point_ff;
   logic signed [31:0] s1_e_ff [4][3];
   logic signed [31:0] s1_t_ff [4];
   logic signed [31:0] s1_c_ff [3];

   // Stage 2: products.
   logic               s2_valid_ff;
   logic               s2_point_ff;
   logic signed [ACC_W-1:0] s2_p_ff [4][3];
   logic signed [ACC_W-1:0] s2_t_ff [4];

   // Stage 3: partial sums.
   logic               s3_valid_ff;
   logic               s3_point_ff;
   logic signed [ACC_W-1:0] s3_a_ff [4];
   logic signed [ACC_W-1:0] s3_b_ff [4];

   // Stage 4: accumulators, row 3 is w.
   logic               s4_valid_ff;
   logic               s4_point_ff;
   logic signed [ACC_W-1:0] s4_acc_ff [4];

   // Stage 5 and the sideband line that runs beside the divider.
   side_type           sb_in;
   logic [ACC_W-1:0]   num_in [3];
   logic [ACC_W-1:0]   den_in;
   logic [ACC_W-1:0]   s5_num_ff [3];
   logic [ACC_W-1:0]   s5_den_ff;
   side_type           sb_ff [DIV_LAT+1];
   logic               sb_valid_ff [DIV_LAT+1];

   // Divider outputs.
   logic [DIV_STEPS-1:0] quo [3];
   logic                 ovf [3];

   // Output register.
   logic signed [31:0] res_in [3];
   logic [2:0]         res_ov;
   logic               out_valid_ff;
   logic signed [31:0] out_x_ff;
   logic signed [31:0] out_y_ff;
   logic signed [31:0] out_z_ff;
   logic               zero_w_ff;
   logic               overflowed_ff;

   // The pipeline moves as a whole unless a result waits at the output.
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign accept        = req_bus.valid && advance;

   // Matrix entries reset to identity; a load transfer writes one entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            fwd_ff[i] <= (i % 5 == 0) ? ENTRY_ONE : '0;
            inv_ff[i] <= (i % 5 == 0) ? ENTRY_ONE : '0;
         end
      end else if (accept && req_bus.mode == MODE_LOAD) begin
         if (req_bus.use_inverse) begin
            inv_ff[req_bus.entry_index] <= req_bus.entry_value;
         end else begin
            fwd_ff[req_bus.entry_index] <= req_bus.entry_value;
         end
      end
   end

   // A normal uses the transposed 3x3 block of the other matrix.
   always_comb begin
      src_inv = (req_bus.mode == MODE_NORMAL) ? !req_bus.use_inverse
                                              : req_bus.use_inverse;
      for (int i = 0; i < 16; i++) begin
         msel[i] = src_inv ? inv_ff[i] : fwd_ff[i];
      end
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 3; k++) begin
            if (req_bus.mode == MODE_NORMAL && r < 3) begin
               e_in[r][k] = msel[k*4+r];
            end else begin
               e_in[r][k] = msel[r*4+k];
            end
         end
         t_in[r] = (req_bus.mode == MODE_POINT) ? msel[r*4+3] : '0;
      end
   end

   // Stage 1 register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && (req_bus.mode != MODE_LOAD);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_point_ff <= (req_bus.mode == MODE_POINT);
         s1_e_ff     <= e_in;
         s1_t_ff     <= t_in;
         s1_c_ff[0]  <= req_bus.in_x;
         s1_c_ff[1]  <= req_bus.in_y;
         s1_c_ff[2]  <= req_bus.in_z;
      end
   end

   // Stage 2: twelve exact products and the scaled translation terms.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_point_ff <= s1_point_ff;
         for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 3; k++) begin
               s2_p_ff[r][k] <= s1_e_ff[r][k] * s1_c_ff[k];
            end
            s2_t_ff[r] <= ACC_W'(s1_t_ff[r]) <<< (FRAC_BITS - 2);
         end
      end
   end

   // Stage 3: products are floored by two bits and summed in pairs.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_point_ff <= s2_point_ff;
         for (int r = 0; r < 4; r++) begin
            s3_a_ff[r] <= (s2_p_ff[r][0] >>> 2) + (s2_p_ff[r][1] >>> 2);
            s3_b_ff[r] <= (s2_p_ff[r][2] >>> 2) + s2_t_ff[r];
         end
      end
   end

   // Stage 4: final accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_point_ff <= s3_point_ff;
         for (int r = 0; r < 4; r++) begin
            s4_acc_ff[r] <= s3_a_ff[r] + s3_b_ff[r];
         end
      end
   end

   // Stage 5: classify w, form the undivided results and the magnitudes.
   always_comb begin
      logic signed [ACC_W-1:0] sh;
      logic                    w_one;
      sb_in.dir_ov = 1'b0;
      for (int r = 0; r < 3; r++) begin
         sh = s4_acc_ff[r] >>> (FRAC_BITS - 2);
         if (sh > ACC_W'(SAT_MAX)) begin
            sb_in.direct[r] = SAT_MAX;
            sb_in.dir_ov    = 1'b1;
         end else if (sh < ACC_W'(SAT_MIN)) begin
            sb_in.direct[r] = SAT_MIN;
            sb_in.dir_ov    = 1'b1;
         end else begin
            sb_in.direct[r] = sh[31:0];
         end
         sb_in.neg[r]    = s4_acc_ff[r][ACC_W-1] ^ s4_acc_ff[3][ACC_W-1];
         sb_in.nonneg[r] = !s4_acc_ff[r][ACC_W-1];
         num_in[r] = s4_acc_ff[r][ACC_W-1] ? ACC_W'(-s4_acc_ff[r]) : ACC_W'(s4_acc_ff[r]);
      end
      w_one         = (s4_acc_ff[3] == ACC_ONE);
      sb_in.w_zero  = s4_point_ff && (s4_acc_ff[3] == '0);
      sb_in.div_sel = s4_point_ff && !w_one && (s4_acc_ff[3] != '0);
      den_in = s4_acc_ff[3][ACC_W-1] ? ACC_W'(-s4_acc_ff[3]) : ACC_W'(s4_acc_ff[3]);
   end

   // Sideband line, one register for stage 5 and one per divider stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_LAT; s++) begin
            sb_valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         sb_valid_ff[0] <= s4_valid_ff;
         for (int s = 1; s <= DIV_LAT; s++) begin
            sb_valid_ff[s] <= sb_valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sb_ff[0]  <= sb_in;
         s5_num_ff <= num_in;
         s5_den_ff <= den_in;
         for (int s = 1; s <= DIV_LAT; s++) begin
            sb_ff[s] <= sb_ff[s-1];
         end
      end
   end

   // One divider lane per component.
   for (genvar r = 0; r < 3; r++) begin : g_lane
      hpvt_div u_div (
         .clock  (clock),
         .enable (advance),
         .num    (s5_num_ff[r]),
         .den    (s5_den_ff),
         .quo    (quo[r]),
         .ovf    (ovf[r])
      );
   end

   // Final selection: zero w, divided, or undivided result.
   always_comb begin
      side_type sb;
      sb = sb_ff[DIV_LAT];
      for (int r = 0; r < 3; r++) begin
         res_ov[r] = 1'b0;
         if (sb.w_zero) begin
            res_in[r] = sb.nonneg[r] ? SAT_MAX : SAT_MIN;
            res_ov[r] = 1'b1;
         end else if (sb.div_sel) begin
            if (!sb.neg[r]) begin
               if (ovf[r] || quo[r] > DIV_STEPS'(SAT_MAX)) begin
                  res_in[r] = SAT_MAX;
                  res_ov[r] = 1'b1;
               end else begin
                  res_in[r] = quo[r][31:0];
               end
            end else begin
               if (ovf[r] || quo[r] > DIV_STEPS'(33'h0_8000_0000)) begin
                  res_in[r] = SAT_MIN;
                  res_ov[r] = 1'b1;
               end else begin
                  res_in[r] = ~quo[r][31:0] + 32'd1;
               end
            end
         end else begin
            res_in[r] = sb.direct[r];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= sb_valid_ff[DIV_LAT];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff      <= res_in[0];
         out_y_ff      <= res_in[1];
         out_z_ff      <= res_in[2];
         zero_w_ff     <= sb_ff[DIV_LAT].w_zero;
         overflowed_ff <= (|res_ov) ||
                          (sb_ff[DIV_LAT].dir_ov && !sb_ff[DIV_LAT].w_zero &&
                           !sb_ff[DIV_LAT].div_sel);
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.out_x      = out_x_ff;
   assign rsp_bus.out_y      = out_y_ff;
   assign rsp_bus.out_z      = out_z_ff;
   assign rsp_bus.zero_w     = zero_w_ff;
   assign rsp_bus.overflowed = overflowed_ff;

endmodule
